// ===== rtl/core/ssem_pkg.sv =====
`timescale 1ns / 1ps

package ssem_pkg;

  localparam int WORD_W = 32;
  localparam int LINE_W = 5;

  // request operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;

  // machine status codes
  localparam logic [1:0] ST_RUNNING = 2'd0;
  localparam logic [1:0] ST_STOPPED = 2'd1;
  localparam logic [1:0] ST_FAULT   = 2'd2;

  // function field, instruction bits 15:13
  localparam logic [2:0] FN_JMP   = 3'd0;
  localparam logic [2:0] FN_JRP   = 3'd1;
  localparam logic [2:0] FN_LDN   = 3'd2;
  localparam logic [2:0] FN_STO   = 3'd3;
  localparam logic [2:0] FN_SUB_A = 3'd4;
  localparam logic [2:0] FN_SUB_B = 3'd5;
  localparam logic [2:0] FN_CMP   = 3'd6;
  localparam logic [2:0] FN_STP   = 3'd7;

  typedef struct packed {
    logic [WORD_W-1:0] ci;
    logic [WORD_W-1:0] acc;
    logic [WORD_W-1:0] pi;
    logic [1:0]        status;
  } arch_state_t;

  typedef struct packed {
    logic              en;
    logic [LINE_W-1:0] line;
    logic [WORD_W-1:0] data;
  } store_wr_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] control_instruction;
    logic [WORD_W-1:0]        present_instruction;
    logic signed [WORD_W-1:0] accumulator;
    logic [WORD_W-1:0]        read_word;
    logic [1:0]               run_status;
  } result_t;

endpackage

// ===== rtl/core/ssem_ifs.sv =====
`timescale 1ns / 1ps

interface ssem_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [4:0]  word_address;
  logic [31:0] write_word;

  modport source (output valid, operation, word_address, write_word, input ready);
  modport sink (input valid, operation, word_address, write_word, output ready);
endinterface

interface ssem_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] control_instruction;
  logic [31:0]        present_instruction;
  logic signed [31:0] accumulator;
  logic [31:0]        read_word;
  logic [1:0]         run_status;

  modport source (output valid, control_instruction, present_instruction, accumulator,
                  read_word, run_status, input ready);
  modport sink (input valid, control_instruction, present_instruction, accumulator,
                read_word, run_status, output ready);
endinterface

// ===== rtl/core/ssem_processor_step_top.sv =====
`timescale 1ns / 1ps

// channel | dir | handshake    | payload
// req     | in  | valid, ready | operation, word_address, write_word
// rsp     | out | valid, ready | control_instruction, present_instruction, accumulator,
//         |     |              | read_word, run_status
//
// one request per cycle while req.ready is high; its response is registered
// the whole step (fetch, operand read, add or subtract) is combinational from the flop store
// a two-deep response buffer (output register plus skid) keeps req ready while one
// response waits; req.ready drops only when both are full
// rst is synchronous: machine registers, status and every store word clear to zero

module ssem_processor_step_top #(
  parameter int STORE_WORDS = 32
) (
  input logic         clk,
  input logic         rst,
  ssem_req_if.sink    req,
  ssem_rsp_if.source  rsp
);

  localparam int AW = $clog2(STORE_WORDS);

  logic [31:0]           store [STORE_WORDS];
  ssem_pkg::arch_state_t state;
  ssem_pkg::arch_state_t state_next;
  ssem_pkg::store_wr_t   wr;
  ssem_pkg::result_t     res;
  ssem_pkg::result_t     out_data;
  ssem_pkg::result_t     skid_data;
  logic                  out_valid;
  logic                  skid_valid;
  logic                  accept;
  logic                  out_fire;

  assign req.ready = !skid_valid;
  assign accept    = req.valid && req.ready;
  assign out_fire  = out_valid && rsp.ready;

  ssem_step_unit #(
    .STORE_WORDS(STORE_WORDS)
  ) u_step (
    .state       (state),
    .store       (store),
    .operation   (req.operation),
    .word_address(req.word_address),
    .write_word  (req.write_word),
    .state_next  (state_next),
    .wr          (wr),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STORE_WORDS; i++) begin
        store[i] <= '0;
      end
    end else if (accept && wr.en) begin
      store[wr.line[AW-1:0]] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (accept) begin
      // skid is empty whenever a request is taken
      if (out_valid && !rsp.ready) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_fire) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (out_valid && !rsp.ready) begin
        skid_data <= res;
      end else begin
        out_data <= res;
      end
    end else if (out_fire && skid_valid) begin
      out_data <= skid_data;
    end
  end

  assign rsp.valid               = out_valid;
  assign rsp.control_instruction = out_data.control_instruction;
  assign rsp.present_instruction = out_data.present_instruction;
  assign rsp.accumulator         = out_data.accumulator;
  assign rsp.read_word           = out_data.read_word;
  assign rsp.run_status          = out_data.run_status;

endmodule

// ===== rtl/core/ssem_step_unit.sv =====
`timescale 1ns / 1ps

module ssem_step_unit #(
  parameter int STORE_WORDS = 32
) (
  input  ssem_pkg::arch_state_t state,
  input  logic [31:0]           store [STORE_WORDS],
  input  logic [1:0]            operation,
  input  logic [4:0]            word_address,
  input  logic [31:0]           write_word,
  output ssem_pkg::arch_state_t state_next,
  output ssem_pkg::store_wr_t   wr,
  output ssem_pkg::result_t     res
);

  localparam int AW = $clog2(STORE_WORDS);
  localparam logic [31:0] DEPTH_W = 32'(STORE_WORDS);
  localparam logic [5:0]  DEPTH_L = 6'(STORE_WORDS);

  logic [31:0] ci_inc;
  logic        ci_in_range;
  logic [31:0] fetched;
  logic [4:0]  line;
  logic [2:0]  func;
  logic        line_in_range;
  logic        addr_in_range;
  logic [31:0] operand;
  logic [31:0] rd;

  assign ci_inc        = state.ci + 32'd1;
  assign ci_in_range   = ci_inc < DEPTH_W;
  assign fetched       = store[ci_inc[AW-1:0]];
  assign line          = fetched[4:0];
  assign func          = fetched[15:13];
  assign line_in_range = {1'b0, line} < DEPTH_L;
  assign addr_in_range = {1'b0, word_address} < DEPTH_L;
  assign operand       = store[line[AW-1:0]];

  always_comb begin
    state_next = state;
    wr         = '0;
    rd         = '0;
    unique case (operation)
      ssem_pkg::OP_WRITE: begin
        if (addr_in_range) begin
          wr.en   = 1'b1;
          wr.line = word_address;
          wr.data = write_word;
        end
      end
      ssem_pkg::OP_READ: begin
        if (addr_in_range) begin
          rd = store[word_address[AW-1:0]];
        end
      end
      ssem_pkg::OP_STEP: begin
        if (state.status == ssem_pkg::ST_RUNNING) begin
          state_next.ci = ci_inc;
          if (!ci_in_range) begin
            state_next.status = ssem_pkg::ST_FAULT;
          end else begin
            state_next.pi = fetched;
            if (!line_in_range) begin
              state_next.status = ssem_pkg::ST_FAULT;
            end else begin
              unique case (func)
                ssem_pkg::FN_JMP: state_next.ci = operand;
                ssem_pkg::FN_JRP: state_next.ci = ci_inc + operand;
                ssem_pkg::FN_LDN: state_next.acc = 32'd0 - operand;
                ssem_pkg::FN_STO: begin
                  wr.en   = 1'b1;
                  wr.line = line;
                  wr.data = state.acc;
                end
                ssem_pkg::FN_SUB_A,
                ssem_pkg::FN_SUB_B: state_next.acc = state.acc - operand;
                ssem_pkg::FN_CMP: begin
                  // skip next instruction when the accumulator is negative
                  if (state.acc[31]) begin
                    state_next.ci = ci_inc + 32'd1;
                  end
                end
                ssem_pkg::FN_STP: state_next.status = ssem_pkg::ST_STOPPED;
                default: ;
              endcase
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign res.control_instruction = $signed(state_next.ci);
  assign res.present_instruction = state_next.pi;
  assign res.accumulator         = $signed(state_next.acc);
  assign res.read_word           = rd;
  assign res.run_status          = state_next.status;

endmodule

// ===== rtl/core/ssem_step_chk.sv =====
`timescale 1ns / 1ps

module ssem_step_chk (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [31:0] rsp_ci,
  input logic [31:0] rsp_acc,
  input logic [1:0]  rsp_status
);

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ci) && $stable(rsp_acc)
                                && $stable(rsp_status))
    else $error("stalled response changed");

  // with no response pending the block must take requests
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("request refused with empty output");

  // a request taken with nothing pending shows up next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && !rsp_valid |=> rsp_valid)
    else $error("response missing one cycle after request");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_status == ssem_pkg::ST_RUNNING || rsp_status == ssem_pkg::ST_STOPPED
                  || rsp_status == ssem_pkg::ST_FAULT)
    else $error("undefined run status");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid && req_ready)
    else $error("output not empty after reset");

endmodule

bind ssem_processor_step_top ssem_step_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_ci    (rsp.control_instruction),
  .rsp_acc   (rsp.accumulator),
  .rsp_status(rsp.run_status)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int WORD_W = ssem_pkg::WORD_W;
  localparam int LINE_W = ssem_pkg::LINE_W;
  localparam int LINES = 32;
  localparam int RANDOM_ITEMS = 900;
  // spare request code, the block should leave everything alone
  localparam logic [1:0] OP_NONE = 2'd3;

  class machine_shadow;
    logic [WORD_W-1:0] mem [LINES];
    logic [WORD_W-1:0] ci;
    logic [WORD_W-1:0] acc;
    logic [WORD_W-1:0] pi;
    logic [1:0]        status;
    ssem_pkg::result_t due_results[$];
    int                errors;

    function new();
      foreach (mem[i]) mem[i] = '0;
      ci = '0;
      acc = '0;
      pi = '0;
      status = ssem_pkg::ST_RUNNING;
      errors = 0;
    endfunction

    function void advance_machine();
      logic [LINE_W-1:0] line;
      logic [WORD_W-1:0] operand;
      if (status != ssem_pkg::ST_RUNNING) return;
      ci = ci + 1;
      // ci is compared unsigned, so a wrap to zero still fetches
      if (ci >= LINES) begin
        status = ssem_pkg::ST_FAULT;
        return;
      end
      pi = mem[ci];
      line = pi[LINE_W-1:0];
      if (line >= LINES) begin
        status = ssem_pkg::ST_FAULT;
        return;
      end
      operand = mem[line];
      case (pi[15:13])
        ssem_pkg::FN_JMP: ci = operand;
        ssem_pkg::FN_JRP: ci = ci + operand;
        ssem_pkg::FN_LDN: acc = -operand;
        ssem_pkg::FN_STO: mem[line] = acc;
        ssem_pkg::FN_SUB_A, ssem_pkg::FN_SUB_B: acc = acc - operand;
        ssem_pkg::FN_CMP: if (acc[WORD_W-1]) ci = ci + 1;
        default: status = ssem_pkg::ST_STOPPED;
      endcase
    endfunction

    function void take_request(logic [1:0] op, logic [LINE_W-1:0] addr,
                               logic [WORD_W-1:0] word);
      ssem_pkg::result_t r;
      r.read_word = '0;
      case (op)
        ssem_pkg::OP_WRITE: if (addr < LINES) mem[addr] = word;
        ssem_pkg::OP_READ: if (addr < LINES) r.read_word = mem[addr];
        ssem_pkg::OP_STEP: advance_machine();
        default: ;
      endcase
      r.control_instruction = ci;
      r.present_instruction = pi;
      r.accumulator = acc;
      r.run_status = status;
      due_results = {due_results, r};
    endfunction

    function void check_reply(ssem_pkg::result_t got);
      ssem_pkg::result_t want;
      logic [WORD_W-1:0] w [5];
      logic [WORD_W-1:0] g [5];
      string             tag [5];
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("response with no request outstanding: %h", got);
        return;
      end
      want = due_results.pop_front();
      tag = '{"control_instruction", "present_instruction", "accumulator", "read_word",
              "run_status"};
      w = '{want.control_instruction, want.present_instruction, want.accumulator,
            want.read_word, WORD_W'(want.run_status)};
      g = '{got.control_instruction, got.present_instruction, got.accumulator,
            got.read_word, WORD_W'(got.run_status)};
      foreach (w[i]) begin
        if (g[i] !== w[i]) begin
          errors++;
          if (errors <= 10)
            $display("mismatch on %s: expected %h got %h", tag[i], w[i], g[i]);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   sent;

  machine_shadow shadow;

  ssem_req_if req ();
  ssem_rsp_if rsp ();

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  ssem_processor_step_top #(
    .STORE_WORDS(LINES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always @(posedge clk) begin
    ssem_pkg::result_t got;
    if (!rst && rsp.valid && rsp.ready) begin
      got.control_instruction = rsp.control_instruction;
      got.present_instruction = rsp.present_instruction;
      got.accumulator = rsp.accumulator;
      got.read_word = rsp.read_word;
      got.run_status = rsp.run_status;
      shadow.check_reply(got);
    end
  end

  // response side: one long hold-off to fill the block, one stretch always ready
  initial begin : rsp_side
    int cyc;
    cyc = 0;
    rsp.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (cyc >= 300 && cyc < 380) begin
        rsp.ready <= 1'b0;
      end else if (cyc >= 700 && cyc < 1000) begin
        rsp.ready <= 1'b1;
      end else begin
        rsp.ready <= ($urandom_range(99, 0) >= 10);
      end
      @(posedge clk);
      cyc++;
    end
  end

  task automatic send(input logic [1:0] op, input logic [LINE_W-1:0] addr,
                      input logic [WORD_W-1:0] word);
    if (!(sent >= 500 && sent < 700) && $urandom_range(99, 0) < 10) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.operation <= op;
    req.word_address <= addr;
    req.write_word <= word;
    do @(posedge clk); while (!req.ready);
    shadow.take_request(op, addr, word);
    sent++;
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (shadow.due_results.size() != 0) @(posedge clk);
  endtask

  // loads an operand and an instruction at the next line, then steps once;
  // for jumps value is the ci wanted after the step
  task automatic run_step(input logic [2:0] fn, input logic [WORD_W-1:0] value);
    logic [WORD_W-1:0] nxt;
    logic [WORD_W-1:0] insn;
    logic [LINE_W-1:0] at;
    logic [LINE_W-1:0] opnd;
    nxt = shadow.ci + 1;
    at = nxt[LINE_W-1:0];
    opnd = LINE_W'($urandom_range(LINES - 1, 0));
    if (fn == ssem_pkg::FN_JMP || fn == ssem_pkg::FN_JRP) begin
      while (opnd == at) opnd = LINE_W'($urandom_range(LINES - 1, 0));
      send(ssem_pkg::OP_WRITE, opnd, (fn == ssem_pkg::FN_JMP) ? value : value - nxt);
    end else begin
      send(ssem_pkg::OP_WRITE, opnd, value);
    end
    insn = $urandom;
    insn[15:13] = fn;
    insn[LINE_W-1:0] = opnd;
    send(ssem_pkg::OP_WRITE, at, insn);
    send(ssem_pkg::OP_STEP, LINE_W'($urandom), $urandom);
  endtask

  // keeps the machine running: no stop, and ci never walks off the store
  function automatic logic [2:0] pick_fn();
    logic [WORD_W-1:0] nxt;
    logic [2:0]        fn;
    nxt = shadow.ci + 1;
    do fn = 3'($urandom_range(ssem_pkg::FN_CMP, ssem_pkg::FN_JMP));
    while ((nxt > LINES - 2 && fn != ssem_pkg::FN_JMP && fn != ssem_pkg::FN_JRP) ||
           (nxt > LINES - 3 && fn == ssem_pkg::FN_CMP));
    return fn;
  endfunction

  task automatic send_noise();
    logic [1:0] op;
    case ($urandom_range(4, 0))
      0, 1: op = ssem_pkg::OP_WRITE;
      2, 3: op = ssem_pkg::OP_READ;
      default: op = OP_NONE;
    endcase
    send(op, LINE_W'($urandom), $urandom);
  endtask

  initial begin : req_side
    logic [2:0]        fn;
    logic [WORD_W-1:0] value;
    logic [LINE_W-1:0] a;
    bit                drained;
    shadow = new();
    sent = 0;
    drained = 0;
    req.valid <= 1'b0;
    req.operation <= ssem_pkg::OP_WRITE;
    req.word_address <= '0;
    req.write_word <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(ssem_pkg::OP_WRITE, 5'd31, 32'hFFFF_FFFF);
    send(ssem_pkg::OP_READ, 5'd31, 32'h0);
    send(OP_NONE, 5'd31, 32'hFFFF_FFFF);
    run_step(ssem_pkg::FN_LDN, 32'd1);
    run_step(ssem_pkg::FN_CMP, $urandom);
    run_step(ssem_pkg::FN_SUB_A, 32'h8000_0000);
    run_step(ssem_pkg::FN_CMP, $urandom);
    run_step(ssem_pkg::FN_SUB_B, 32'hFFFF_FFFF);
    run_step(ssem_pkg::FN_STO, $urandom);
    // ci wraps to zero on the next fetch
    run_step(ssem_pkg::FN_JMP, 32'hFFFF_FFFF);
    run_step(ssem_pkg::FN_JRP, 32'd5);

    while (sent < RANDOM_ITEMS) begin
      if (!drained && sent >= 300) begin
        drain();
        drained = 1;
      end
      if ($urandom_range(99, 0) < 20) begin
        send_noise();
      end else begin
        fn = pick_fn();
        if (fn == ssem_pkg::FN_JMP || fn == ssem_pkg::FN_JRP) begin
          value = ($urandom_range(15, 0) == 0) ? '1 : $urandom_range(LINES - 2, 0);
        end else begin
          value = $urandom;
        end
        run_step(fn, value);
      end
    end

    // halt at the very end, since only reset clears the status
    if ($urandom_range(1, 0)) begin
      run_step(ssem_pkg::FN_STP, $urandom);
    end else begin
      run_step(ssem_pkg::FN_JMP, $urandom_range(32'hFFFF_FFFE, LINES - 1));
      send(ssem_pkg::OP_STEP, LINE_W'($urandom), $urandom);
    end
    a = LINE_W'($urandom);
    send(ssem_pkg::OP_STEP, LINE_W'($urandom), $urandom);
    send(ssem_pkg::OP_WRITE, a, $urandom);
    send(ssem_pkg::OP_READ, a, $urandom);
    send(OP_NONE, LINE_W'($urandom), $urandom);
    send(ssem_pkg::OP_STEP, LINE_W'($urandom), $urandom);

    drain();
    repeat (10) @(posedge clk);
    if (shadow.errors == 0 && shadow.due_results.size() == 0) begin
      $display("[ssem_processor_step_top] OK");
    end else begin
      $display("[ssem_processor_step_top] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("[ssem_processor_step_top] ERROR");
    $finish;
  end

endmodule

// ===== ssem_processor_step_top.f =====
rtl/core/ssem_pkg.sv
rtl/core/ssem_ifs.sv
rtl/core/ssem_step_unit.sv
rtl/core/ssem_processor_step_top.sv
rtl/core/ssem_step_chk.sv
dv/tb_top.sv
